/* design/mrdp_pkg.sv */
package mrdp_pkg;

  // Configuration register indexes.
  localparam logic [0:0] CFG_PRIME = 1'b0;
  localparam logic [0:0] CFG_FINAL = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_ACC,
    ST_FIN,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic red_step;
    logic mul_step;
    logic acc_en;
    logic fin_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } status_t;

endpackage

/* design/mrdp_in_if.sv */
interface mrdp_in_if #(
  parameter int ELEM_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [ELEM_BITS-1:0] matrix_element;
  logic [ELEM_BITS-1:0] vector_element;
  logic                 row_end;

  modport source (output valid, output matrix_element, output vector_element,
                  output row_end, input ready);
  modport sink (input valid, input matrix_element, input vector_element,
                input row_end, output ready);
endinterface

/* design/mrdp_out_if.sv */
interface mrdp_out_if #(
  parameter int ELEM_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [ELEM_BITS-1:0] row_result;

  modport source (output valid, output row_result, input ready);
  modport sink (input valid, input row_result, output ready);
endinterface

/* design/modular_row_dot_product.sv */
// Modular row dot product.
// Input channel in_ch carries one transaction per row element: matrix_element,
// vector_element and row_end, which marks the last element of a row. Each
// element is multiplied by its vector element modulo the prime register and
// added modulo the prime into a running sum. The transaction with row_end set
// produces one output transaction on out_ch with row_result, the sum reduced
// by the final modulus register when that register is nonzero; the sum is
// then cleared. Configuration is written through cfg_we_i, cfg_idx_i
// and cfg_data_i; the user must write it only while the block is
// idle, as the block itself does not enforce this. One element
// occupies the block for a load, one bit-serial remainder pass, one
// bit-serial shift-add multiply pass and an accumulate step. A row
// end adds the final remainder pass and a step that loads the output
// register. The output register holds a result until the receiver
// takes it while the next element is already processed; a second result
// waits in the controller until the register is free. Reset clears the sum,
// the control state and the output valid and restores the register defaults.
module modular_row_dot_product #(
  parameter int ELEM_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mrdp_in_if.sink              in_ch,
  mrdp_out_if.source           out_ch,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [ELEM_BITS-1:0] cfg_data_i
);
  import mrdp_pkg::*;

  cmd_t    cmd;
  status_t status;

  mrdp_ctrl #(.ELEM_BITS(ELEM_BITS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mrdp_datapath #(.ELEM_BITS(ELEM_BITS)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .matrix_element_i (in_ch.matrix_element),
    .vector_element_i (in_ch.vector_element),
    .row_end_i        (in_ch.row_end),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .row_result_o     (out_ch.row_result)
  );

endmodule

/* design/mrdp_datapath.sv */
module mrdp_datapath #(
  parameter int ELEM_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mrdp_pkg::cmd_t       cmd_i,
  output mrdp_pkg::status_t    status_o,
  input  logic [ELEM_BITS-1:0] matrix_element_i,
  input  logic [ELEM_BITS-1:0] vector_element_i,
  input  logic                 row_end_i,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [ELEM_BITS-1:0] cfg_data_i,
  output logic [ELEM_BITS-1:0] row_result_o
);
  import mrdp_pkg::*;

  localparam int W = ELEM_BITS;
  localparam logic [W-1:0] PRIME_RST = W'(64'h0000_0000_FFFF_FFFB);

  logic [W-1:0] prime_q, final_q;
  logic [W-1:0] sum_q;
  logic [W-1:0] xa_q, ra_q;
  logic [W-1:0] xs_q, rs_q;
  logic [W-1:0] b_q, acc_q;
  logic [W-1:0] out_q;
  logic         last_q;

  logic [W-1:0] ra_d, rs_d, mul_d, add_d, ms;
  logic [W+1:0] mul_s, mul_p1, mul_p2;
  logic [W:0]   add_s;

  // One restoring step of a remainder: shift in one dividend bit, subtract if it fits.
  // A modulus of zero subtracts zero, so the dividend passes through unchanged.
  function automatic logic [W-1:0] rem_step(input logic [W-1:0] r, input logic bit_in,
                                            input logic [W-1:0] m);
    logic [W:0] sh;
    sh = {r, bit_in};
    if (sh >= {1'b0, m}) begin
      rem_step = W'(sh - {1'b0, m});
    end else begin
      rem_step = sh[W-1:0];
    end
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= PRIME_RST;
      final_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRIME: prime_q <= cfg_data_i;
        CFG_FINAL: final_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Remainder lanes: lane A reduces the matrix element, lane S the sum.
  assign ms   = cmd_i.fin_step ? final_q : prime_q;
  assign ra_d = rem_step(ra_q, xa_q[W-1], prime_q);
  assign rs_d = rem_step(rs_q, xs_q[W-1], ms);

  // Shift-add multiply step: 2*acc + a is below 3P, so subtract P or 2P at most.
  always_comb begin
    mul_s  = {1'b0, acc_q, 1'b0} + (b_q[W-1] ? {2'b00, ra_q} : '0);
    mul_p1 = {2'b00, prime_q};
    mul_p2 = {1'b0, prime_q, 1'b0};
    if (prime_q == '0) begin
      mul_d = mul_s[W-1:0];
    end else if (mul_s >= mul_p2) begin
      mul_d = W'(mul_s - mul_p2);
    end else if (mul_s >= mul_p1) begin
      mul_d = W'(mul_s - mul_p1);
    end else begin
      mul_d = mul_s[W-1:0];
    end
  end

  // Modular add of the reduced sum and the product.
  always_comb begin
    add_s = {1'b0, rs_q} + {1'b0, acc_q};
    if (prime_q == '0) begin
      add_d = add_s[W-1:0];
    end else if (add_s >= {1'b0, prime_q}) begin
      add_d = W'(add_s - {1'b0, prime_q});
    end else begin
      add_d = add_s[W-1:0];
    end
  end

  // Running sum is control state and is cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (cmd_i.acc_en) begin
      sum_q <= last_q ? '0 : add_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      xa_q   <= matrix_element_i;
      ra_q   <= '0;
      xs_q   <= sum_q;
      rs_q   <= '0;
      b_q    <= vector_element_i;
      acc_q  <= '0;
      last_q <= row_end_i;
    end
    if (cmd_i.red_step) begin
      xa_q <= {xa_q[W-2:0], 1'b0};
      ra_q <= ra_d;
    end
    if (cmd_i.red_step || cmd_i.fin_step) begin
      xs_q <= {xs_q[W-2:0], 1'b0};
      rs_q <= rs_d;
    end
    if (cmd_i.mul_step) begin
      b_q   <= {b_q[W-2:0], 1'b0};
      acc_q <= mul_d;
    end
    if (cmd_i.acc_en && last_q) begin
      xs_q <= add_d;
      rs_q <= '0;
    end
    if (cmd_i.out_load) begin
      out_q <= rs_q;
    end
  end

  assign status_o.last = last_q;
  assign row_result_o  = out_q;

endmodule

/* design/mrdp_ctrl.sv */
module mrdp_ctrl #(
  parameter int ELEM_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mrdp_pkg::status_t status_i,
  output mrdp_pkg::cmd_t    cmd_o
);
  import mrdp_pkg::*;

  localparam int CW = $clog2(ELEM_BITS);
  localparam logic [CW-1:0] CNT_LAST = CW'(ELEM_BITS - 1);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic          cnt_done, out_free;

  assign cnt_done = (cnt_q == CNT_LAST);
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_REDUCE;
      ST_REDUCE: if (cnt_done) state_d = ST_MUL;
      ST_MUL:    if (cnt_done) state_d = ST_ACC;
      ST_ACC:    state_d = status_i.last ? ST_FIN : ST_IDLE;
      ST_FIN:    if (cnt_done) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_REDUCE: cmd_o.red_step = 1'b1;
      ST_MUL:    cmd_o.mul_step = 1'b1;
      ST_ACC:    cmd_o.acc_en   = 1'b1;
      ST_FIN:    cmd_o.fin_step = 1'b1;
      ST_DONE:   cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  // Bit counter for the serial phases and the output valid flag.
  always_comb begin
    cnt_d = '0;
    if ((state_q == ST_REDUCE || state_q == ST_MUL || state_q == ST_FIN) && !cnt_done) begin
      cnt_d = cnt_q + CW'(1);
    end
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* design/mrdp_checker.sv */
module mrdp_checker #(
  parameter int ELEM_BITS = 32
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [ELEM_BITS-1:0] row_result_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(row_result_i))
    else $error("stalled result changed");

  // An element keeps the block busy for the serial passes.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i ##1 !in_ready_i)
    else $error("input accepted while busy");

  // A result cannot appear right after an element is taken.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_i))
    else $error("result appeared too early");

  // A new result is loaded only while the input side is closed.
  a_rose_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result loaded while idle");

endmodule

bind modular_row_dot_product mrdp_checker #(.ELEM_BITS(ELEM_BITS)) u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .row_result_i (out_ch.row_result)
);
